@@ rtl/stfl_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot table free list package
// Sizes, command and status codes, and the classified request that passes
// from the front queue to the execution back end.
// ----------------------------------------------------------------------------
package stfl_pkg;

  localparam int CAPACITY = 256;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_OCCUPY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
    logic               idx_in_cap;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
  } req_t;

endpackage

@@ rtl/stfl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module stfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/stfl_front.sv @@
// ----------------------------------------------------------------------------
// Slot table front end
// Accepts requests, checks the index against the capacity and holds them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module stfl_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [stfl_pkg::CMD_W-1:0]   cmd,
  input  logic [stfl_pkg::INDEX_W-1:0] slot_index,
  input  logic [stfl_pkg::DATA_W-1:0]  item_data,
  output logic                         q_valid,
  output stfl_pkg::req_t               q_req,
  input  logic                         q_pop
);
  import stfl_pkg::*;

  req_t               entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         fill;
  logic               push;
  req_t               req_in;
  logic [INDEX_W-1:0] idx_m1;

  assign idx_m1 = slot_index - INDEX_W'(1);

  always_comb begin
    req_in.cmd        = cmd;
    req_in.idx        = slot_index;
    req_in.idx_in_cap = (slot_index != '0) && (slot_index <= INDEX_W'(CAPACITY));
    req_in.addr       = idx_m1[ADDR_W-1:0];
    req_in.data       = item_data;
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_req    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && q_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ rtl/stfl_back.sv @@
// ----------------------------------------------------------------------------
// Slot table back end
// Carries out occupy, release and read against the slot store, the link
// store and the occupied marks, and holds the result in an output register.
// ----------------------------------------------------------------------------
module stfl_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  stfl_pkg::req_t                q_req,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stfl_pkg::INDEX_W-1:0]  granted_index,
  output logic [stfl_pkg::DATA_W-1:0]   read_word,
  output logic [stfl_pkg::STATUS_W-1:0] status,
  output logic [stfl_pkg::INDEX_W-1:0]  highest_index
);
  import stfl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LINK = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_MARK = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [INDEX_W-1:0]  head;
  logic [INDEX_W-1:0]  head_next;
  logic [INDEX_W-1:0]  count;
  logic [INDEX_W-1:0]  count_next;
  logic [INDEX_W-1:0]  max_g;
  logic [INDEX_W-1:0]  max_next;
  logic                occ_set;
  logic                occ_clr;
  logic                occ_we;
  logic                occ_re;
  logic                occ_rdata;
  logic [ADDR_W-1:0]   occ_addr;

  logic                store_we;
  logic [ADDR_W-1:0]   store_waddr;
  logic                store_re;
  logic [DATA_W-1:0]   store_rdata;
  logic                link_we;
  logic                link_re;
  logic [ADDR_W-1:0]   link_addr;
  logic [INDEX_W-1:0]  link_rdata;

  logic                out_free;
  logic                load;
  logic [INDEX_W-1:0]  res_granted;
  logic [DATA_W-1:0]   res_word;
  logic [STATUS_W-1:0] res_status;
  logic                idx_ok;
  logic [INDEX_W-1:0]  tail_slot;
  logic [INDEX_W-1:0]  head_m1;

  assign out_free  = !out_valid || !out_stall;
  assign idx_ok    = q_req.idx_in_cap && (q_req.idx <= count);
  assign tail_slot = count + INDEX_W'(1);
  assign head_m1   = head - INDEX_W'(1);
  assign occ_we    = occ_set || occ_clr;

  stfl_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (q_req.data),
    .re    (store_re),
    .raddr (q_req.addr),
    .rdata (store_rdata)
  );

  stfl_ram #(.WIDTH(INDEX_W), .DEPTH(CAPACITY)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (q_req.addr),
    .wdata (head),
    .re    (link_re),
    .raddr (link_addr),
    .rdata (link_rdata)
  );

  stfl_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_addr),
    .wdata (occ_set),
    .re    (occ_re),
    .raddr (q_req.addr),
    .rdata (occ_rdata)
  );

  always_comb begin
    state_next  = state;
    head_next   = head;
    count_next  = count;
    max_next    = max_g;
    occ_set     = 1'b0;
    occ_clr     = 1'b0;
    occ_re      = 1'b0;
    occ_addr    = q_req.addr;
    store_we    = 1'b0;
    store_waddr = q_req.addr;
    store_re    = 1'b0;
    link_we     = 1'b0;
    link_re     = 1'b0;
    link_addr   = head_m1[ADDR_W-1:0];
    q_pop       = 1'b0;
    load        = 1'b0;
    res_granted = '0;
    res_word    = '0;
    res_status  = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_req.cmd)
            CMD_OCCUPY: begin
              load = 1'b1;
              if (head == '0) begin
                if (count >= INDEX_W'(CAPACITY)) begin
                  res_status = ST_FULL;
                end else begin
                  count_next  = tail_slot;
                  store_we    = 1'b1;
                  store_waddr = count[ADDR_W-1:0];
                  occ_set     = 1'b1;
                  occ_addr    = count[ADDR_W-1:0];
                  if (tail_slot > max_g) begin
                    max_next = tail_slot;
                  end
                  res_granted = tail_slot;
                end
              end else begin
                store_we    = 1'b1;
                store_waddr = head_m1[ADDR_W-1:0];
                link_re     = 1'b1;
                occ_set     = 1'b1;
                occ_addr    = head_m1[ADDR_W-1:0];
                res_granted = head;
                state_next  = S_LINK;
              end
            end
            CMD_RELEASE: begin
              if (!idx_ok) begin
                load       = 1'b1;
                res_status = ST_RANGE;
              end else begin
                q_pop      = 1'b0;
                occ_re     = 1'b1;
                state_next = S_MARK;
              end
            end
            CMD_READ: begin
              if (!idx_ok) begin
                load       = 1'b1;
                res_status = ST_RANGE;
              end else begin
                store_re   = 1'b1;
                state_next = S_READ;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_LINK: begin
        head_next  = link_rdata;
        state_next = S_IDLE;
      end
      S_READ: begin
        if (out_free) begin
          load       = 1'b1;
          res_word   = store_rdata;
          state_next = S_IDLE;
        end
      end
      S_MARK: begin
        if (out_free) begin
          q_pop = 1'b1;
          load  = 1'b1;
          if (!occ_rdata) begin
            res_status = ST_DOUBLE;
          end else begin
            occ_clr   = 1'b1;
            link_we   = 1'b1;
            head_next = q_req.idx;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      max_g     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      max_g <= max_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      granted_index <= res_granted;
      read_word     <= res_word;
      status        <= res_status;
      highest_index <= max_next;
    end
  end

endmodule

@@ rtl/slot_table_free_list.sv @@
// ----------------------------------------------------------------------------
// Slot table with a free list: the back end completes occupy, unused and out-of-range
// requests in its idle state; an occupy that takes a chained slot adds a link-read state.
// Read and in-range release pass through a store or mark read state before their result
// is loaded; every result is loaded into the output register only when it is free.
// Reset clears the control state only; marks are read only for slots already appended.
// ----------------------------------------------------------------------------
module slot_table_free_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stfl_pkg::CMD_W-1:0]    cmd,
  input  logic [stfl_pkg::INDEX_W-1:0]  slot_index,
  input  logic [stfl_pkg::DATA_W-1:0]   item_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stfl_pkg::INDEX_W-1:0]  granted_index,
  output logic [stfl_pkg::DATA_W-1:0]   read_word,
  output logic [stfl_pkg::STATUS_W-1:0] status,
  output logic [stfl_pkg::INDEX_W-1:0]  highest_index
);
  import stfl_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_req;

  stfl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .slot_index (slot_index),
    .item_data  (item_data),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop)
  );

  stfl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted_index (granted_index),
    .read_word     (read_word),
    .status        (status),
    .highest_index (highest_index)
  );

endmodule

@@ dv/slot_table_free_list_check.sv @@
// ----------------------------------------------------------------------------
// Slot table free list checker
// Watches both channels of the slot table. It keeps its own copy of the table
// and the free chain, works out the result of each accepted request, and
// compares every returned result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module slot_table_free_list_check
  import stfl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [INDEX_W-1:0]  slot_index,
  input  logic [DATA_W-1:0]   item_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [INDEX_W-1:0]  granted_index,
  input  logic [DATA_W-1:0]   read_word,
  input  logic [STATUS_W-1:0] status,
  input  logic [INDEX_W-1:0]  highest_index,
  output int                  errors,
  output int                  outstanding,
  output int                  results_checked,
  output int                  full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [INDEX_W-1:0]  granted;
    logic [DATA_W-1:0]   word;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  highest;
  } slot_result_t;

  logic [DATA_W-1:0]  words [1:CAPACITY];
  bit                 marks [1:CAPACITY];
  logic [INDEX_W-1:0] links [1:CAPACITY];
  logic [INDEX_W-1:0] free_head;
  int                 appended;
  int                 top_granted;

  slot_result_t pending_results[$];
  int           fail_total = 0;
  int           checked_total = 0;
  int           full_total = 0;

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got_v,
                               input logic [DATA_W-1:0] want_v);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got_v,
             want_v);
    fail_total++;
  endtask

  function automatic slot_result_t apply_request(input logic [CMD_W-1:0] op,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic [DATA_W-1:0] d);
    slot_result_t r;
    int slot;
    bit in_range;
    r = '0;
    in_range = (idx >= 1) && (int'(idx) <= appended);
    case (op)
      CMD_OCCUPY: begin
        if (free_head == '0) begin
          if (appended >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            appended++;
            slot = appended;
            marks[slot] = 1'b1;
            links[slot] = '0;
            words[slot] = d;
            if (slot > top_granted) top_granted = slot;
            r.granted = INDEX_W'(slot);
          end
        end else begin
          slot = int'(free_head);
          free_head = links[slot];
          marks[slot] = 1'b1;
          words[slot] = d;
          r.granted = INDEX_W'(slot);
        end
      end
      CMD_RELEASE: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else if (!marks[idx]) begin
          r.status = ST_DOUBLE;
        end else begin
          marks[idx] = 1'b0;
          links[idx] = free_head;
          free_head = idx;
        end
      end
      CMD_READ: begin
        if (!in_range) r.status = ST_RANGE;
        else r.word = words[idx];
      end
      default: begin
      end
    endcase
    r.highest = INDEX_W'(top_granted);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    slot_result_t got;
    slot_result_t want;
    if (rst) begin
      for (int i = 1; i <= CAPACITY; i++) marks[i] = 1'b0;
      free_head = '0;
      appended = 0;
      top_granted = 0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{granted_index, read_word, status, highest_index};
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no request waiting, granted_index",
                        DATA_W'(got.granted), '0);
        end else begin
          want = pending_results.pop_front();
          if (got.granted !== want.granted)
            flag_mismatch("granted_index", DATA_W'(got.granted), DATA_W'(want.granted));
          if (got.word !== want.word) flag_mismatch("read_word", got.word, want.word);
          if (got.status !== want.status)
            flag_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
          if (got.highest !== want.highest)
            flag_mismatch("highest_index", DATA_W'(got.highest), DATA_W'(want.highest));
          checked_total++;
          if (want.status == ST_FULL) full_total++;
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(apply_request(cmd, slot_index, item_data));
    end
    outstanding <= pending_results.size();
    errors <= fail_total;
    results_checked <= checked_total;
    full_seen <= full_total;
  end

endmodule

@@ dv/slot_table_free_list_test.sv @@
// ----------------------------------------------------------------------------
// Slot table free list testbench
// Drives occupy, release, read and unused requests into the slot table with
// random gaps and output stalls: a short directed run, a random mix, a burst
// of occupies filling the table, a release-heavy mix, a last mix. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module slot_table_free_list_test;
  import stfl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                HALF_PERIOD = 6;
  localparam int                CYCLE_LIMIT = 400000;
  localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [INDEX_W-1:0] IDX_TOP    = '1;
  localparam logic [DATA_W-1:0] DATA_ONES   = '1;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd;
  logic [INDEX_W-1:0]  slot_index;
  logic [DATA_W-1:0]   item_data;
  logic                out_valid;
  logic                out_stall;
  logic [INDEX_W-1:0]  granted_index;
  logic [DATA_W-1:0]   read_word;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  highest_index;

  int errors;
  int outstanding;
  int results_checked;
  int full_seen;

  int cycles = 0;
  int n_occupy = 0;
  int n_release = 0;
  int n_read = 0;
  int n_unused = 0;
  int gap_left = 0;
  bit gap_calm = 1'b0;

  slot_table_free_list u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .slot_index    (slot_index),
    .item_data     (item_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted_index (granted_index),
    .read_word     (read_word),
    .status        (status),
    .highest_index (highest_index)
  );

  slot_table_free_list_check u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .slot_index      (slot_index),
    .item_data       (item_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .granted_index   (granted_index),
    .read_word       (read_word),
    .status          (status),
    .highest_index   (highest_index),
    .errors          (errors),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .full_seen       (full_seen)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(input logic [CMD_W-1:0] op, input logic [INDEX_W-1:0] idx,
                      input logic [DATA_W-1:0] d);
    int gap;
    if (gap_left == 0) begin
      gap_calm = ($urandom_range(0, 3) == 0);
      gap_left = $urandom_range(20, 80);
    end
    gap_left--;
    gap = gap_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    slot_index <= idx;
    item_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (op)
      CMD_OCCUPY:  n_occupy++;
      CMD_RELEASE: n_release++;
      CMD_READ:    n_read++;
      default:     n_unused++;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic random_request(input int occupy_pct);
    int r;
    int rest;
    int hi;
    logic [CMD_W-1:0] op;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0] d;
    r = $urandom_range(0, 99);
    rest = 100 - occupy_pct;
    if (r < occupy_pct) op = CMD_OCCUPY;
    else if ((r - occupy_pct) * 100 < rest * 55) op = CMD_RELEASE;
    else if ((r - occupy_pct) * 100 < rest * 92) op = CMD_READ;
    else op = CMD_UNUSED;
    hi = (n_occupy > CAPACITY) ? CAPACITY : n_occupy;
    if (hi < 1) hi = 1;
    if ($urandom_range(0, 9) == 0) idx = INDEX_W'($urandom_range(0, int'(IDX_TOP)));
    else idx = INDEX_W'($urandom_range(1, hi));
    case ($urandom_range(0, 15))
      0:       d = '0;
      1:       d = DATA_ONES;
      default: d = $urandom;
    endcase
    send(op, idx, d);
  endtask

  initial begin : sink
    int hold;
    int mode_left;
    bit calm;
    mode_left = 0;
    calm = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      hold = calm ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin : stimulus
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_OCCUPY;
    slot_index <= '0;
    item_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(CMD_OCCUPY, '0, '0);
    send(CMD_OCCUPY, IDX_TOP, DATA_ONES);
    send(CMD_OCCUPY, 9'd5, 32'hA5A5_5A5A);
    send(CMD_READ, 9'd1, '0);
    send(CMD_READ, 9'd2, '0);
    send(CMD_READ, 9'd0, '0);
    send(CMD_READ, 9'd4, '0);
    send(CMD_READ, IDX_TOP, DATA_ONES);
    send(CMD_RELEASE, 9'd0, '0);
    send(CMD_RELEASE, 9'd256, '0);
    send(CMD_RELEASE, 9'd2, '0);
    send(CMD_RELEASE, 9'd2, '0);
    send(CMD_READ, 9'd2, '0);
    send(CMD_RELEASE, 9'd1, '0);
    send(CMD_OCCUPY, '0, 32'h1234_5678);
    send(CMD_OCCUPY, '0, 32'h8765_4321);
    send(CMD_OCCUPY, '0, 32'hDEAD_BEEF);
    send(CMD_RELEASE, IDX_TOP, '0);
    send(CMD_UNUSED, IDX_TOP, DATA_ONES);
    send(CMD_UNUSED, 9'd1, '0);
    send(CMD_READ, 9'd4, '0);
    drain();

    repeat (200) random_request(45);
    drain();

    // Enough occupies in a row to empty the free chain and exhaust the table.
    repeat (300) send(CMD_OCCUPY, INDEX_W'($urandom_range(0, int'(IDX_TOP))), $urandom);

    repeat (200) random_request(30);
    drain();
    repeat (200) random_request(40);

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests: %0d occupy, %0d release, %0d read, %0d unused command.",
             n_occupy + n_release + n_read + n_unused, n_occupy, n_release, n_read,
             n_unused);
    $display("Compared %0d results, %0d of them with the table full.", results_checked,
             full_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
